FILE: rtl/core/bmh_pkg.sv
// Package for the block median hash: sizes, widths and sequencer states.
`timescale 1ns / 1ps

package bmh_pkg;

    localparam int FRAME_SIDE   = 64;
    localparam int GRID_SIDE    = 8;
    localparam int BAND_COUNT   = 4;

    localparam int BLOCK_SIDE   = FRAME_SIDE / GRID_SIDE;
    localparam int BLOCK_COUNT  = GRID_SIDE * GRID_SIDE;
    localparam int BAND_SIZE    = BLOCK_COUNT / BAND_COUNT;
    localparam int LUMA_BYTES   = FRAME_SIDE * FRAME_SIDE;
    localparam int CHROMA_BYTES = LUMA_BYTES / 4;
    localparam int CHROMA_ROW   = FRAME_SIDE / 4;
    localparam int FRAME_BYTES  = LUMA_BYTES + 2 * CHROMA_BYTES;

    // middle ranks of a sorted band; equal for an odd band size
    localparam int MID_HI = BAND_SIZE / 2;
    localparam int MID_LO = (BAND_SIZE % 2 == 0) ? BAND_SIZE / 2 - 1 : BAND_SIZE / 2;

    localparam int SAMPLE_W = 8;
    localparam int SUM_W    = 16;
    localparam int AMT_W    = SAMPLE_W + 2;
    localparam int HASH_W   = 64;
    localparam int POS_W    = $clog2(FRAME_BYTES);
    localparam int BLK_W    = $clog2(BLOCK_COUNT);
    localparam int BIDX_W   = (BAND_SIZE > 1) ? $clog2(BAND_SIZE) : 1;
    localparam int BAND_W   = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
    localparam int CNT_W    = $clog2(BAND_SIZE + 1);

    localparam logic [SUM_W-1:0] SUM_MAX    = '1;
    localparam logic [SUM_W-1:0] THR_RESET  = 16'd245;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_CAND,
        S_CAND_WAIT,
        S_SCAN,
        S_EVAL,
        S_MED,
        S_THR_START,
        S_THR,
        S_EMIT
    } t_bmh_state;

endpackage

FILE: rtl/core/block_median_hash_64.sv
// Block median hash: block sums of a planar 4:1:1 frame, band medians, 64-bit hash.
//
// Input: one frame byte per request on the s_axis channel, tdata = sample,
// tuser = frame_start (clears position and sums before the byte is taken).
// Bytes come 4096 luma, 1024 Cb, 1024 Cr. Output: one 64-bit hash per frame
// on the m_axis channel, bit j for block j in raster order.
// Config: i_cfg_we writes diff_threshold from i_cfg_wdata; write while idle.
//
// Each byte takes two steps: a read of the block sum memory, then a
// saturating add and write back; the next byte is taken only after the
// write back. After the last byte the sequencer ranks each block of a
// band against every block of that band with a less-than and a
// less-or-equal compare, then forms the band median and makes the
// threshold pass; after all four bands the hash loads into the output register.
// Bytes of the next frame are taken while a hash waits on the output; only
// a second finished hash stalls the sequencer until the first is taken.
// Reset clears the position, the valid bits of the sum memory, the pending
// hash and sets the threshold to 245. Valid bits also clear at frame start
// and at frame end, so sums never need a clearing sweep.
`timescale 1ns / 1ps

module block_median_hash_64 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] sample
    input  logic        i_s_axis_tuser,   // [0] frame_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [63:0] hash
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    localparam int BLK_W  = bmh_pkg::BLK_W;
    localparam int BIDX_W = bmh_pkg::BIDX_W;
    localparam int BAND_W = bmh_pkg::BAND_W;
    localparam int CNT_W  = bmh_pkg::CNT_W;
    localparam int POS_W  = bmh_pkg::POS_W;
    localparam int SUM_W  = bmh_pkg::SUM_W;
    localparam int AMT_W  = bmh_pkg::AMT_W;

    // control state
    bmh_pkg::t_bmh_state r_state, n_state;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [SUM_W-1:0]    r_thr, n_thr;
    logic [bmh_pkg::BLOCK_COUNT-1:0] r_vld, n_vld;
    logic [BAND_W-1:0]   r_band, n_band;
    logic [BIDX_W-1:0]   r_i, n_i;
    logic [BIDX_W-1:0]   r_j, n_j;
    logic [CNT_W-1:0]    r_lt, n_lt;
    logic [CNT_W-1:0]    r_le, n_le;
    logic                r_last, n_last;
    logic                r_o_valid, n_o_valid;
    logic [bmh_pkg::HASH_W-1:0] r_hash_acc, n_hash_acc;
    logic [SUM_W-1:0]    r_median, n_median;

    // payload
    logic [SUM_W-1:0]    r_mem [bmh_pkg::BLOCK_COUNT];
    logic [SUM_W-1:0]    r_rd_data;
    logic                r_rd_ok;
    logic [BLK_W-1:0]    r_waddr, n_waddr;
    logic [AMT_W-1:0]    r_amount, n_amount;
    logic [SUM_W-1:0]    r_cand, n_cand;
    logic [SUM_W-1:0]    r_lo, n_lo;
    logic [SUM_W-1:0]    r_hi, n_hi;
    logic [bmh_pkg::HASH_W-1:0] r_hash_out, n_hash_out;

    logic                accept;
    logic [POS_W-1:0]    pos_cur;
    logic [POS_W-1:0]    k_off;
    logic [31:0]         blk_wide;
    logic [BLK_W-1:0]    byte_blk;
    logic [BLK_W-1:0]    band_base;
    logic [BLK_W-1:0]    rd_addr;
    logic                rd_ok_n;
    logic [SUM_W-1:0]    rdval;
    logic [SUM_W:0]      add_sum;
    logic [SUM_W-1:0]    wr_data;
    logic                wr_en;
    logic [SUM_W-1:0]    abs_diff;
    logic [SUM_W:0]      mid_sum;

    assign o_s_axis_tready = (r_state == bmh_pkg::S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_hash_out;

    assign rdval     = r_rd_ok ? r_rd_data : '0;
    assign band_base = BLK_W'(32'(r_band) * bmh_pkg::BAND_SIZE);

    // block index of the incoming byte
    always_comb begin
        pos_cur = i_s_axis_tuser ? '0 : r_pos;
        k_off   = pos_cur - POS_W'(bmh_pkg::LUMA_BYTES);
        if (k_off >= POS_W'(bmh_pkg::CHROMA_BYTES)) begin
            k_off = k_off - POS_W'(bmh_pkg::CHROMA_BYTES);
        end
        if (pos_cur < POS_W'(bmh_pkg::LUMA_BYTES)) begin
            blk_wide = 32'((32'(pos_cur) / bmh_pkg::FRAME_SIDE) / bmh_pkg::BLOCK_SIDE
                           * bmh_pkg::GRID_SIDE
                           + (32'(pos_cur) % bmh_pkg::FRAME_SIDE) / bmh_pkg::BLOCK_SIDE);
        end else begin
            // chroma byte spreads over four luma columns
            blk_wide = 32'((32'(k_off) / bmh_pkg::CHROMA_ROW) / bmh_pkg::BLOCK_SIDE
                           * bmh_pkg::GRID_SIDE
                           + (32'(k_off) % bmh_pkg::CHROMA_ROW) * 4 / bmh_pkg::BLOCK_SIDE);
        end
        byte_blk = blk_wide[BLK_W-1:0];
    end

    // shared arithmetic
    assign add_sum  = {1'b0, rdval} + (SUM_W+1)'(r_amount);
    assign wr_data  = add_sum[SUM_W] ? bmh_pkg::SUM_MAX : add_sum[SUM_W-1:0];
    assign abs_diff = (rdval > r_median) ? rdval - r_median : r_median - rdval;
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_thr      = i_cfg_we ? i_cfg_wdata : r_thr;
        n_vld      = r_vld;
        n_band     = r_band;
        n_i        = r_i;
        n_j        = r_j;
        n_lt       = r_lt;
        n_le       = r_le;
        n_last     = r_last;
        n_o_valid  = r_o_valid && !i_m_axis_tready;
        n_hash_acc = r_hash_acc;
        n_median   = r_median;
        n_waddr    = r_waddr;
        n_amount   = r_amount;
        n_cand     = r_cand;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_hash_out = r_hash_out;
        rd_addr    = band_base;
        wr_en      = 1'b0;

        unique case (r_state)
            bmh_pkg::S_IDLE: begin
                rd_addr = byte_blk;
                if (accept) begin
                    if (i_s_axis_tuser) begin
                        n_vld = '0;
                    end
                    n_waddr = byte_blk;
                    n_amount = (pos_cur < POS_W'(bmh_pkg::LUMA_BYTES))
                             ? AMT_W'(i_s_axis_tdata)
                             : {i_s_axis_tdata, 2'b00};
                    n_last  = (pos_cur == POS_W'(bmh_pkg::FRAME_BYTES - 1));
                    n_pos   = pos_cur + POS_W'(1);
                    n_state = bmh_pkg::S_ADD;
                end
            end
            bmh_pkg::S_ADD: begin
                wr_en = 1'b1;
                n_vld[r_waddr] = 1'b1;
                if (r_last) begin
                    n_band     = '0;
                    n_i        = '0;
                    n_hash_acc = '0;
                    n_state    = bmh_pkg::S_CAND;
                end else begin
                    n_state = bmh_pkg::S_IDLE;
                end
            end
            bmh_pkg::S_CAND: begin
                rd_addr = band_base + BLK_W'(r_i);
                n_state = bmh_pkg::S_CAND_WAIT;
            end
            bmh_pkg::S_CAND_WAIT: begin
                n_cand  = rdval;
                n_lt    = '0;
                n_le    = '0;
                n_j     = '0;
                rd_addr = band_base;
                n_state = bmh_pkg::S_SCAN;
            end
            bmh_pkg::S_SCAN: begin
                // rank the candidate against block r_j of the band
                rd_addr = band_base + BLK_W'(r_j) + BLK_W'(1);
                if (rdval < r_cand) begin
                    n_lt = r_lt + CNT_W'(1);
                end
                if (rdval <= r_cand) begin
                    n_le = r_le + CNT_W'(1);
                end
                n_j = r_j + BIDX_W'(1);
                if (r_j == BIDX_W'(bmh_pkg::BAND_SIZE - 1)) begin
                    n_state = bmh_pkg::S_EVAL;
                end
            end
            bmh_pkg::S_EVAL: begin
                // candidate occupies sorted places lt .. le-1
                if (r_lt <= CNT_W'(bmh_pkg::MID_LO) && CNT_W'(bmh_pkg::MID_LO) < r_le) begin
                    n_lo = r_cand;
                end
                if (r_lt <= CNT_W'(bmh_pkg::MID_HI) && CNT_W'(bmh_pkg::MID_HI) < r_le) begin
                    n_hi = r_cand;
                end
                n_i = r_i + BIDX_W'(1);
                if (r_i == BIDX_W'(bmh_pkg::BAND_SIZE - 1)) begin
                    n_state = bmh_pkg::S_MED;
                end else begin
                    n_state = bmh_pkg::S_CAND;
                end
            end
            bmh_pkg::S_MED: begin
                n_median = mid_sum[SUM_W:1];
                n_state  = bmh_pkg::S_THR_START;
            end
            bmh_pkg::S_THR_START: begin
                rd_addr = band_base;
                n_j     = '0;
                n_state = bmh_pkg::S_THR;
            end
            bmh_pkg::S_THR: begin
                rd_addr = band_base + BLK_W'(r_j) + BLK_W'(1);
                if (abs_diff > r_thr) begin
                    n_hash_acc[band_base + BLK_W'(r_j)] = 1'b1;
                end
                n_j = r_j + BIDX_W'(1);
                if (r_j == BIDX_W'(bmh_pkg::BAND_SIZE - 1)) begin
                    n_i = '0;
                    if (r_band == BAND_W'(bmh_pkg::BAND_COUNT - 1)) begin
                        n_state = bmh_pkg::S_EMIT;
                    end else begin
                        n_band  = r_band + BAND_W'(1);
                        n_state = bmh_pkg::S_CAND;
                    end
                end
            end
            bmh_pkg::S_EMIT: begin
                if (!r_o_valid || i_m_axis_tready) begin
                    n_o_valid  = 1'b1;
                    n_hash_out = r_hash_acc;
                    n_vld      = '0;
                    n_pos      = '0;
                    n_state    = bmh_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bmh_pkg::S_IDLE;
            end
        endcase

        rd_ok_n = r_vld[rd_addr] && !(accept && i_s_axis_tuser);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bmh_pkg::S_IDLE;
            r_pos      <= '0;
            r_thr      <= bmh_pkg::THR_RESET;
            r_vld      <= '0;
            r_band     <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_lt       <= '0;
            r_le       <= '0;
            r_last     <= 1'b0;
            r_o_valid  <= 1'b0;
            r_hash_acc <= '0;
            r_median   <= '0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_thr      <= n_thr;
            r_vld      <= n_vld;
            r_band     <= n_band;
            r_i        <= n_i;
            r_j        <= n_j;
            r_lt       <= n_lt;
            r_le       <= n_le;
            r_last     <= n_last;
            r_o_valid  <= n_o_valid;
            r_hash_acc <= n_hash_acc;
            r_median   <= n_median;
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr    <= n_waddr;
        r_amount   <= n_amount;
        r_cand     <= n_cand;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_hash_out <= n_hash_out;
        r_rd_ok    <= rd_ok_n;
    end

    // block sum memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_waddr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

endmodule
